// ===== rtl/tspc_pkg.sv =====
// Shared types and constants for the tile and sprite pixel compositor.
`default_nettype none
package tspc_pkg;

  localparam logic [2:0] ACT_MAP    = 3'd0;
  localparam logic [2:0] ACT_BG_GFX = 3'd1;
  localparam logic [2:0] ACT_SP_GFX = 3'd2;
  localparam logic [2:0] ACT_SPRITE = 3'd3;
  localparam logic [2:0] ACT_PIXEL  = 3'd4;

  localparam logic [1:0] CFG_BG_PAL  = 2'd0;
  localparam logic [1:0] CFG_SP_PAL0 = 2'd1;
  localparam logic [1:0] CFG_SP_PAL1 = 2'd2;

  localparam logic [7:0] PALETTE_RESET = 8'hE4;
  localparam logic [8:0] SPRITE_Y_LIMIT = 9'd160;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] tile;
    logic [7:0] flags;
  } sprite_t;

  function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
    logic [23:0] rgb;
    unique case (shade)
      2'd0: rgb = 24'hE0F8D0;
      2'd1: rgb = 24'h88C070;
      2'd2: rgb = 24'h346856;
      default: rgb = 24'h081820;
    endcase
    return rgb;
  endfunction

  function automatic logic [1:0] pal_pick(input logic [7:0] pal, input logic [1:0] idx);
    return pal[{idx, 1'b0} +: 2];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tspc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tspc_cell.sv =====
// One sprite table cell: holds an entry, loads on write, rotates during a scan.
`default_nettype none
module tspc_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tspc_pkg::sprite_t load_data,
  input  wire logic              shift,
  input  wire tspc_pkg::sprite_t shift_in,
  output tspc_pkg::sprite_t      entry
);
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (load) begin
      entry <= load_data;
    end else if (shift) begin
      entry <= shift_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tile_sprite_pixel_compositor_core.sv =====
// Top level of the tile and sprite pixel compositor.
//
// Input channel (in_valid/in_ready): one item per transfer. Map, graphics and
// sprite writes give no result. A pixel query gives one result on the output
// channel (out_valid/out_ready).
// A query reads the tile map, then the background graphics, then rotates the
// ring of sprite cells once past a head evaluator that reads the sprite
// graphics RAM: one sprite per cycle. The query then passes the drain and
// finish states before its result is registered in the output register.
// in_ready is high whenever no query is in flight; the next item can be taken
// while a result waits in the output register. If the receiver stalls and a
// new result is done, the block holds it until the output register frees.
// Reset clears the sprite table (all sprites hidden); palettes reset to 0xE4.
// Map and graphics stores are not cleared and must be written first. Palettes
// go via cfg_we/cfg_index/cfg_data; user writes only while idle, unenforced.
`default_nettype none
module tile_sprite_pixel_compositor_core #(
  parameter int MAP_COLUMNS  = 20,
  parameter int MAP_ROWS     = 18,
  parameter int SPRITE_COUNT = 40,
  parameter int TILE_COUNT   = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] action,
  input  wire logic [11:0] address,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] sprite_y,
  input  wire logic [7:0] sprite_x,
  input  wire logic [7:0] sprite_tile,
  input  wire logic [7:0] sprite_flags,
  input  wire logic [7:0] pixel_x,
  input  wire logic [7:0] pixel_y,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue,
  output logic [1:0]      shade,
  output logic            from_sprite,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam int MAP_SIZE = MAP_COLUMNS * MAP_ROWS;
  localparam int MAW      = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int GDEPTH   = TILE_COUNT * 8;
  localparam int GAW      = $clog2(GDEPTH);
  localparam int SIW      = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam logic [8:0]  SCREEN_W = 9'(MAP_COLUMNS * 8);
  localparam logic [8:0]  SCREEN_H = 9'(MAP_ROWS * 8);
  localparam logic [11:0] MAP_LIMIT = 12'(MAP_SIZE);
  localparam logic [12:0] GFX_LIMIT = 13'(TILE_COUNT * 16);
  localparam logic [8:0]  TILE_LIMIT = 9'(TILE_COUNT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_BG    = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state, state_next;
  logic       in_xfer;
  logic [7:0] bg_pal, sp_pal0, sp_pal1;

  // query context
  logic [7:0] px, py;
  logic       onscreen;
  logic       bg_tile_ok;
  logic [1:0] bg_idx;

  // scan
  logic [SIW-1:0] scan_cnt;
  logic           b_valid;
  logic           b_cand;
  logic [2:0]     b_col;
  logic           b_behind;
  logic           b_pal1;
  logic           won;
  logic [1:0]     won_shade;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // palettes
  always_ff @(posedge clk) begin
    if (rst) begin
      bg_pal  <= tspc_pkg::PALETTE_RESET;
      sp_pal0 <= tspc_pkg::PALETTE_RESET;
      sp_pal1 <= tspc_pkg::PALETTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tspc_pkg::CFG_BG_PAL:  bg_pal  <= cfg_data;
        tspc_pkg::CFG_SP_PAL0: sp_pal0 <= cfg_data;
        tspc_pkg::CFG_SP_PAL1: sp_pal1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // tile map
  logic [10:0]    map_raddr_w;
  logic [MAW-1:0] map_raddr;
  logic [7:0]     map_rdata;
  logic           map_we;

  assign map_raddr_w = 11'(pixel_y[7:3]) * 11'(MAP_COLUMNS) + 11'(pixel_x[7:3]);
  assign map_raddr   = map_raddr_w[MAW-1:0];
  assign map_we      = in_xfer && action == tspc_pkg::ACT_MAP && address < MAP_LIMIT;

  tspc_ram #(.WIDTH(8), .DEPTH(MAP_SIZE)) u_map (
    .clk(clk), .we(map_we), .waddr(address[MAW-1:0]), .wdata(data_byte),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // graphics stores, split into even (low plane) and odd (high plane) bytes
  logic           gfx_ok;
  logic           bg_we_lo, bg_we_hi, sp_we_lo, sp_we_hi;
  logic [GAW-1:0] gfx_waddr;
  logic [10:0]    bg_raddr_w, sp_raddr_w;
  logic [7:0]     bg_lo, bg_hi, sp_lo, sp_hi;

  assign gfx_ok    = {1'b0, address} < GFX_LIMIT;
  assign gfx_waddr = address[GAW:1];
  assign bg_we_lo  = in_xfer && action == tspc_pkg::ACT_BG_GFX && gfx_ok && !address[0];
  assign bg_we_hi  = in_xfer && action == tspc_pkg::ACT_BG_GFX && gfx_ok && address[0];
  assign sp_we_lo  = in_xfer && action == tspc_pkg::ACT_SP_GFX && gfx_ok && !address[0];
  assign sp_we_hi  = in_xfer && action == tspc_pkg::ACT_SP_GFX && gfx_ok && address[0];
  assign bg_raddr_w = {map_rdata, py[2:0]};

  tspc_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_bg_lo (
    .clk(clk), .we(bg_we_lo), .waddr(gfx_waddr), .wdata(data_byte),
    .raddr(bg_raddr_w[GAW-1:0]), .rdata(bg_lo)
  );
  tspc_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_bg_hi (
    .clk(clk), .we(bg_we_hi), .waddr(gfx_waddr), .wdata(data_byte),
    .raddr(bg_raddr_w[GAW-1:0]), .rdata(bg_hi)
  );
  tspc_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_sp_lo (
    .clk(clk), .we(sp_we_lo), .waddr(gfx_waddr), .wdata(data_byte),
    .raddr(sp_raddr_w[GAW-1:0]), .rdata(sp_lo)
  );
  tspc_ram #(.WIDTH(8), .DEPTH(GDEPTH)) u_sp_hi (
    .clk(clk), .we(sp_we_hi), .waddr(gfx_waddr), .wdata(data_byte),
    .raddr(sp_raddr_w[GAW-1:0]), .rdata(sp_hi)
  );

  // sprite ring
  tspc_pkg::sprite_t cells [SPRITE_COUNT];
  tspc_pkg::sprite_t new_entry;
  logic              shift;

  assign new_entry = '{y: sprite_y, x: sprite_x, tile: sprite_tile, flags: sprite_flags};
  assign shift     = (state == ST_SCAN);

  for (genvar i = 0; i < SPRITE_COUNT; i++) begin : g_cell
    tspc_cell u_cell (
      .clk(clk), .rst(rst),
      .load(in_xfer && action == tspc_pkg::ACT_SPRITE && address == 12'(i)),
      .load_data(new_entry),
      .shift(shift),
      .shift_in(cells[(i + 1) % SPRITE_COUNT]),
      .entry(cells[i])
    );
  end

  // head evaluation
  tspc_pkg::sprite_t head;
  logic [8:0] pyo, pxo, dy, dx;
  logic       h_vis, h_cover, h_tile_ok, h_cand;
  logic [2:0] h_row, h_col;

  assign head      = cells[0];
  assign pyo       = {1'b0, py} + 9'd16;
  assign pxo       = {1'b0, px} + 9'd8;
  assign dy        = pyo - {1'b0, head.y};
  assign dx        = pxo - {1'b0, head.x};
  assign h_vis     = head.y != 8'd0 && {1'b0, head.y} < tspc_pkg::SPRITE_Y_LIMIT;
  assign h_cover   = pyo >= {1'b0, head.y} && dy < 9'd8 && pxo >= {1'b0, head.x} && dx < 9'd8;
  assign h_tile_ok = {1'b0, head.tile} < TILE_LIMIT;
  assign h_cand    = onscreen && h_vis && h_cover && h_tile_ok;
  assign h_row     = dy[2:0] ^ {3{head.flags[6]}};
  assign h_col     = dx[2:0] ^ {3{head.flags[5]}};
  assign sp_raddr_w = {head.tile, h_row};

  // decode stage
  logic [1:0] sp_idx, b_shade, final_shade;
  logic       b_win;

  assign sp_idx  = {sp_hi[3'd7 - b_col], sp_lo[3'd7 - b_col]};
  assign b_win   = b_valid && b_cand && sp_idx != 2'd0 && !(b_behind && bg_idx != 2'd0) && !won;
  assign b_shade = tspc_pkg::pal_pick(b_pal1 ? sp_pal1 : sp_pal0, sp_idx);
  assign final_shade = won ? won_shade : tspc_pkg::pal_pick(bg_pal, bg_idx);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_xfer && action == tspc_pkg::ACT_PIXEL) state_next = ST_MAP;
      ST_MAP:   state_next = ST_BG;
      ST_BG:    state_next = ST_SCAN;
      ST_SCAN:  if (scan_cnt == SIW'(SPRITE_COUNT - 1)) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      b_valid   <= 1'b0;
      won       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      b_valid <= (state == ST_SCAN);
      if (state == ST_BG) begin
        scan_cnt <= '0;
        won      <= 1'b0;
      end else if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + SIW'(1);
      end
      if (b_win) begin
        won <= 1'b1;
      end
      if (state == ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && action == tspc_pkg::ACT_PIXEL) begin
      px       <= pixel_x;
      py       <= pixel_y;
      onscreen <= {1'b0, pixel_x} < SCREEN_W && {1'b0, pixel_y} < SCREEN_H;
    end
    if (state == ST_MAP) begin
      bg_tile_ok <= {1'b0, map_rdata} < TILE_LIMIT;
    end
    if (state == ST_BG) begin
      bg_idx <= (onscreen && bg_tile_ok) ? {bg_hi[3'd7 - px[2:0]], bg_lo[3'd7 - px[2:0]]}
                                         : 2'd0;
    end
    b_cand   <= h_cand;
    b_col    <= h_col;
    b_behind <= head.flags[7];
    b_pal1   <= head.flags[4];
    if (b_win) begin
      won_shade <= b_shade;
    end
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      {red, green, blue} <= tspc_pkg::shade_rgb(final_shade);
      shade       <= final_shade;
      from_sprite <= won;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_cnt <= SIW'(SPRITE_COUNT - 1))
    else $error("sprite scan ran past the last cell");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result appeared outside the finish step");

  a_win_once: assert property (@(posedge clk) disable iff (rst)
    b_win |-> !won && state != ST_IDLE)
    else $error("second sprite win within one query");

endmodule
`default_nettype wire
